[hdl/svpc_pkg.sv]
`timescale 1ns / 1ps
package svpc_pkg;

   localparam int unsigned SECTOR_SPAN_DEF = 10922;
   localparam logic [15:0] PERIOD_RESET    = 16'd3125;

   // radians per angle unit in Q46 is 2^32 + RAD_PER_UNIT_LO
   localparam logic [31:0] RAD_PER_UNIT_LO  = 32'd2451551557;
   localparam logic [31:0] TWO_BY_SQRT3_Q16 = 32'd75675;
   localparam logic [30:0] Q30_ONE          = 31'h4000_0000;

   // exact reciprocals for 31-bit dividends: q = (v * RECIP) >> shift
   localparam logic [31:0] RECIP_72 = 32'd3817748708;  // shift 38
   localparam logic [31:0] RECIP_42 = 32'd3272356036;  // shift 37
   localparam logic [31:0] RECIP_20 = 32'd3435973837;  // shift 36
   localparam logic [31:0] RECIP_6  = 32'd2863311531;  // shift 34

   localparam logic [2:0] SECTOR_LAST = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SECT,
      ST_ISSUE,
      ST_WB,
      ST_ADJ,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_RAD,
      OP_SQR,
      OP_D72,
      OP_H42,
      OP_D42,
      OP_H20,
      OP_D20,
      OP_H6,
      OP_D6,
      OP_SIN,
      OP_SCALE,
      OP_AMPPER,
      OP_TA,
      OP_TB
   } op_type;

   typedef struct packed {
      logic [15:0] compare_a;
      logic [15:0] compare_b;
      logic [15:0] compare_c;
      logic [2:0]  sector;
      logic [13:0] sector_angle;
   } result_type;

endpackage

[hdl/space_vector_pwm_compare_gen.sv]
`timescale 1ns / 1ps
// Flow: once a transaction is accepted, the sector is found by repeated subtraction,
// 25 products pass through the shared 32x32 multiplier, then the timing and compare
// logic run; rsp_valid rises when the result is written to the output register.
// A new transaction is taken only once the core is idle again; a finished result may wait
// in the output register while the next transaction is taken.
// Reset clears the phase accumulator, loads pwm_period with 3125, drops rsp_valid.
module space_vector_pwm_compare_gen #(
   parameter int unsigned SECTOR_SPAN = svpc_pkg::SECTOR_SPAN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_angle_step,
   input  logic [13:0] req_amplitude,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_compare_a,
   output logic [15:0] rsp_compare_b,
   output logic [15:0] rsp_compare_c,
   output logic [2:0]  rsp_sector,
   output logic [13:0] rsp_sector_angle,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import svpc_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [15:0] period_ff, period_in;
   logic        start;
   logic        idle;
   logic        reg_sel;
   result_type  rsp_data;

   assign start   = req_valid && idle;
   assign acc_in  = start ? (acc_ff + req_angle_step) : acc_ff;
   assign reg_sel = (csr_paddr[2] == 1'b0);

   always_comb begin
      period_in = period_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         period_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 32'd0;
         period_ff <= PERIOD_RESET;
      end else begin
         acc_ff    <= acc_in;
         period_ff <= period_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? {16'd0, period_ff} : 32'd0;

   svpc_core #(
      .SECTOR_SPAN (SECTOR_SPAN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .angle     (acc_in[31:16]),
      .amplitude (req_amplitude),
      .period    (period_ff),
      .rsp_stall (rsp_stall),
      .idle      (idle),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_stall        = !idle;
   assign rsp_compare_a    = rsp_data.compare_a;
   assign rsp_compare_b    = rsp_data.compare_b;
   assign rsp_compare_c    = rsp_data.compare_c;
   assign rsp_sector       = rsp_data.sector;
   assign rsp_sector_angle = rsp_data.sector_angle;

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sector <= SECTOR_LAST &&
                     {2'd0, rsp_sector_angle} < 16'(SECTOR_SPAN)))
      else $error("sector or sector angle out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("ready again right after a transaction was accepted");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a transaction in progress");

endmodule

[hdl/svpc_mul.sv]
`timescale 1ns / 1ps
module svpc_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);

   logic [63:0] prod_in;

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[hdl/svpc_core.sv]
`timescale 1ns / 1ps
module svpc_core #(
   parameter int unsigned SECTOR_SPAN = svpc_pkg::SECTOR_SPAN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          angle,
   input  logic [13:0]          amplitude,
   input  logic [15:0]          period,
   input  logic                 rsp_stall,
   output logic                 idle,
   output logic                 rsp_valid,
   output svpc_pkg::result_type rsp_data
);
   import svpc_pkg::*;

   localparam logic [15:0] SPAN16 = 16'(SECTOR_SPAN);
   localparam logic [13:0] SPAN14 = 14'(SECTOR_SPAN);

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic        pass_ff, pass_in;
   logic [2:0]  sec_ff, sec_in;
   logic [15:0] rem_ff, rem_in;
   logic [13:0] sa_ff, sa_in;
   logic [13:0] amp_ff, amp_in;
   logic [30:0] r_ff, r_in;
   logic [30:0] r2_ff, r2_in;
   logic [30:0] work_ff, work_in;
   logic [14:0] sn_ff, sn_in;
   logic [31:0] scale_a_ff, scale_a_in;
   logic [31:0] scale_b_ff, scale_b_in;
   logic [29:0] ap_ff, ap_in;
   logic [15:0] ta_ff, ta_in;
   logic [15:0] tb_ff, tb_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;
   logic [13:0] x_val;
   logic        out_free;
   logic        sect_more;
   logic [46:0] rad_sum;
   logic [32:0] sin_rnd;
   logic [17:0] sin_q;
   logic [17:0] time_q;
   logic [15:0] time_sat;
   logic [16:0] tab_sum;
   logic [15:0] t0_val;
   logic [16:0] t0_ta, t0_tb, p_t0;

   function automatic logic [15:0] sat_to(input logic [16:0] v, input logic [15:0] p);
      sat_to = (v > {1'b0, p}) ? p : v[15:0];
   endfunction

   svpc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign x_val     = pass_ff ? sa_ff : (SPAN14 - sa_ff);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign sect_more = (rem_ff >= SPAN16) && (sec_ff != SECTOR_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      pass_in  = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SECT;
            end
         end
         ST_SECT: begin
            if (!sect_more) begin
               state_in = ST_ISSUE;
               op_in    = OP_RAD;
               pass_in  = 1'b0;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            state_in = ST_ISSUE;
            case (op_ff)
               OP_RAD:    op_in = OP_SQR;
               OP_SQR:    op_in = OP_D72;
               OP_D72:    op_in = OP_H42;
               OP_H42:    op_in = OP_D42;
               OP_D42:    op_in = OP_H20;
               OP_H20:    op_in = OP_D20;
               OP_D20:    op_in = OP_H6;
               OP_H6:     op_in = OP_D6;
               OP_D6:     op_in = OP_SIN;
               OP_SIN:    op_in = OP_SCALE;
               OP_SCALE: begin
                  if (pass_ff) begin
                     op_in = OP_AMPPER;
                  end else begin
                     op_in   = OP_RAD;
                     pass_in = 1'b1;
                  end
               end
               OP_AMPPER: op_in = OP_TA;
               OP_TA:     op_in = OP_TB;
               OP_TB:     state_in = ST_ADJ;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_ADJ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: handshake and multiplier operands
   always_comb begin
      idle  = (state_ff == ST_IDLE);
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (op_ff)
         OP_RAD: begin
            mul_a = {18'd0, x_val};
            mul_b = RAD_PER_UNIT_LO;
         end
         OP_SQR: begin
            mul_a = {1'b0, r_ff};
            mul_b = {1'b0, r_ff};
         end
         OP_D72: begin
            mul_a = {1'b0, r2_ff};
            mul_b = RECIP_72;
         end
         OP_H42, OP_H20, OP_H6: begin
            mul_a = {1'b0, r2_ff};
            mul_b = {1'b0, work_ff};
         end
         OP_D42: begin
            mul_a = {1'b0, work_ff};
            mul_b = RECIP_42;
         end
         OP_D20: begin
            mul_a = {1'b0, work_ff};
            mul_b = RECIP_20;
         end
         OP_D6: begin
            mul_a = {1'b0, work_ff};
            mul_b = RECIP_6;
         end
         OP_SIN: begin
            mul_a = {1'b0, r_ff};
            mul_b = {1'b0, work_ff};
         end
         OP_SCALE: begin
            mul_a = {17'd0, sn_ff};
            mul_b = TWO_BY_SQRT3_Q16;
         end
         OP_AMPPER: begin
            mul_a = {18'd0, amp_ff};
            mul_b = {16'd0, period};
         end
         OP_TA: begin
            mul_a = scale_a_ff;
            mul_b = {2'd0, ap_ff};
         end
         OP_TB: begin
            mul_a = scale_b_ff;
            mul_b = {2'd0, ap_ff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   // datapath
   always_comb begin
      sec_in       = sec_ff;
      rem_in       = rem_ff;
      sa_in        = sa_ff;
      amp_in       = amp_ff;
      r_in         = r_ff;
      r2_in        = r2_ff;
      work_in      = work_ff;
      sn_in        = sn_ff;
      scale_a_in   = scale_a_ff;
      scale_b_in   = scale_b_ff;
      ap_in        = ap_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      rad_sum  = {1'b0, prod_ff[45:0]} + {1'b0, x_val, 32'd0};
      sin_rnd  = {1'b0, prod_ff[61:30]} + 33'h0_0000_4000;
      sin_q    = sin_rnd[32:15];
      time_q   = prod_ff[61:44];
      time_sat = (time_q > {2'd0, period}) ? period : time_q[15:0];
      tab_sum  = {1'b0, ta_ff} + {1'b0, tb_ff};
      t0_val   = (period - ta_ff - tb_ff) >> 1;
      t0_ta    = {1'b0, t0_val} + {1'b0, ta_ff};
      t0_tb    = {1'b0, t0_val} + {1'b0, tb_ff};
      p_t0     = {1'b0, period - t0_val};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in = angle;
               sec_in = 3'd0;
               amp_in = amplitude;
            end
         end
         ST_SECT: begin
            if (sect_more) begin
               rem_in = rem_ff - SPAN16;
               sec_in = sec_ff + 3'd1;
            end else if (rem_ff >= SPAN16) begin
               // angle beyond the last full sector: pin to its end
               sa_in = SPAN14 - 14'd1;
            end else begin
               sa_in = rem_ff[13:0];
            end
         end
         ST_WB: begin
            case (op_ff)
               OP_RAD:  r_in    = rad_sum[46:16];
               OP_SQR:  r2_in   = prod_ff[60:30];
               OP_D72:  work_in = Q30_ONE - {5'd0, prod_ff[63:38]};
               OP_D42:  work_in = Q30_ONE - {4'd0, prod_ff[63:37]};
               OP_D20:  work_in = Q30_ONE - {3'd0, prod_ff[63:36]};
               OP_D6:   work_in = Q30_ONE - {1'b0, prod_ff[63:34]};
               OP_H42, OP_H20, OP_H6: begin
                  work_in = prod_ff[60:30];
               end
               OP_SIN:  sn_in = (sin_q > 18'd32767) ? 15'h7FFF : sin_q[14:0];
               OP_SCALE: begin
                  if (pass_ff) begin
                     scale_b_in = prod_ff[31:0];
                  end else begin
                     scale_a_in = prod_ff[31:0];
                  end
               end
               OP_AMPPER: ap_in = prod_ff[29:0];
               OP_TA:     ta_in = time_sat;
               OP_TB:     tb_in = time_sat;
               default: begin
                  r_in = r_ff;
               end
            endcase
         end
         ST_ADJ: begin
            // cut the smaller active time (or set both to half on a tie) so the pair fits the period
            if (tab_sum > {1'b0, period}) begin
               if (ta_ff > tb_ff) begin
                  tb_in = period - ta_ff;
               end else if (tb_ff > ta_ff) begin
                  ta_in = period - tb_ff;
               end else begin
                  ta_in = period >> 1;
                  tb_in = period >> 1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.sector       = sec_ff;
               out_in.sector_angle = sa_ff;
               case (sec_ff)
                  3'd0: begin
                     out_in.compare_a = sat_to({1'b0, t0_val}, period);
                     out_in.compare_b = sat_to(t0_ta, period);
                     out_in.compare_c = sat_to(p_t0, period);
                  end
                  3'd1: begin
                     out_in.compare_a = sat_to(t0_tb, period);
                     out_in.compare_b = sat_to({1'b0, t0_val}, period);
                     out_in.compare_c = sat_to(p_t0, period);
                  end
                  3'd2: begin
                     out_in.compare_a = sat_to(p_t0, period);
                     out_in.compare_b = sat_to({1'b0, t0_val}, period);
                     out_in.compare_c = sat_to(t0_ta, period);
                  end
                  3'd3: begin
                     out_in.compare_a = sat_to(p_t0, period);
                     out_in.compare_b = sat_to(t0_tb, period);
                     out_in.compare_c = sat_to({1'b0, t0_val}, period);
                  end
                  3'd4: begin
                     out_in.compare_a = sat_to(t0_ta, period);
                     out_in.compare_b = sat_to(p_t0, period);
                     out_in.compare_c = sat_to({1'b0, t0_val}, period);
                  end
                  default: begin
                     out_in.compare_a = sat_to({1'b0, t0_val}, period);
                     out_in.compare_b = sat_to(p_t0, period);
                     out_in.compare_c = sat_to(t0_tb, period);
                  end
               endcase
            end
         end
         default: begin
            sec_in = sec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RAD;
         pass_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pass_ff      <= pass_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff     <= sec_in;
      rem_ff     <= rem_in;
      sa_ff      <= sa_in;
      amp_ff     <= amp_in;
      r_ff       <= r_in;
      r2_ff      <= r2_in;
      work_ff    <= work_in;
      sn_ff      <= sn_in;
      scale_a_ff <= scale_a_in;
      scale_b_ff <= scale_b_in;
      ap_ff      <= ap_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
   import svpc_pkg::*;

   localparam int unsigned SPAN           = SECTOR_SPAN_DEF;
   localparam logic [2:0]  PERIOD_ADDR    = 3'd0;
   localparam logic [63:0] RAD_Q46        = 64'd6746518853;
   localparam logic [63:0] GAIN_Q16       = 64'd75675;
   localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
   localparam int unsigned IDLE_PCT       = 12;
   localparam int unsigned PHASE_ITEMS    = 183;
   localparam int unsigned QUIET_FROM     = 700;
   localparam int unsigned QUIET_TO       = 1000;
   localparam int unsigned HOLD_AT        = 260;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned DRAIN_CYCLES   = 70;
   localparam int unsigned WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [31:0] step;
      logic [13:0] amplitude;
   } pwm_update_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_angle_step = '0;
   logic [13:0] req_amplitude = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_compare_a;
   logic [15:0] rsp_compare_b;
   logic [15:0] rsp_compare_c;
   logic [2:0]  rsp_sector;
   logic [13:0] rsp_sector_angle;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pwm_update_type pwm_updates[$];
   result_type     expected_compares[$];
   pwm_update_type next_update;
   result_type     want;
   logic [31:0]  phase_model = '0;
   logic [15:0]  period_model = PERIOD_RESET;
   logic [31:0]  plan_phase = '0;
   int unsigned  pushed_count = 0;
   int unsigned  updates_sent = 0;
   int unsigned  checked_count = 0;
   int unsigned  hold_left = 0;
   bit           hold_done = 0;
   int unsigned  mismatches = 0;
   int unsigned  idle_cycles = 0;

   space_vector_pwm_compare_gen dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_angle_step(req_angle_step),
      .req_amplitude(req_amplitude),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_compare_a(rsp_compare_a),
      .rsp_compare_b(rsp_compare_b),
      .rsp_compare_c(rsp_compare_c),
      .rsp_sector(rsp_sector),
      .rsp_sector_angle(rsp_sector_angle),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Q1.15 sine of an angle in turn/65536 units, Taylor series to x^9 in Q30
   function automatic logic [15:0] q15_sine(input logic [15:0] x);
      logic [63:0] rad, rad_sq, poly, s;
      rad = (64'(x) * RAD_Q46) >> 16;
      rad_sq = (rad * rad) >> 30;
      poly = ONE_Q30 - rad_sq / 64'd72;
      poly = ONE_Q30 - ((rad_sq * poly) >> 30) / 64'd42;
      poly = ONE_Q30 - ((rad_sq * poly) >> 30) / 64'd20;
      poly = ONE_Q30 - ((rad_sq * poly) >> 30) / 64'd6;
      s = (rad * poly) >> 30;
      s = (s + 64'd16384) >> 15;
      return (s > 64'd32767) ? 16'd32767 : s[15:0];
   endfunction

   function automatic logic [31:0] on_time(input logic [15:0] sine, input logic [13:0] amp,
                                           input logic [15:0] period);
      logic [63:0] prod;
      prod = (64'(sine) * 64'(amp) * 64'(period) * GAIN_Q16) >> 44;
      return (prod > 64'(period)) ? 32'(period) : prod[31:0];
   endfunction

   task automatic predict_compares(input logic [31:0] step, input logic [13:0] amp);
      logic [15:0] angle;
      logic [31:0] sec, sa, ta, tb, t0, per, ca, cb, cc;
      result_type  res;
      phase_model = phase_model + step;
      angle = phase_model[31:16];
      sec = angle / SPAN;
      sa = angle % SPAN;
      // the last partial sector folds onto the end of sector 5
      if (sec > 32'(SECTOR_LAST)) begin
         sec = 32'(SECTOR_LAST);
         sa = SPAN - 1;
      end
      per = 32'(period_model);
      ta = on_time(q15_sine(16'(SPAN - sa)), amp, period_model);
      tb = on_time(q15_sine(sa[15:0]), amp, period_model);
      if (ta + tb > per) begin
         if (ta > tb) tb = per - ta;
         else if (tb > ta) ta = per - tb;
         else begin
            ta = per >> 1;
            tb = per >> 1;
         end
      end
      t0 = (per - ta - tb) >> 1;
      case (sec)
         0: begin ca = t0;       cb = t0 + ta;   cc = per - t0; end
         1: begin ca = t0 + tb;  cb = t0;        cc = per - t0; end
         2: begin ca = per - t0; cb = t0;        cc = t0 + ta;  end
         3: begin ca = per - t0; cb = t0 + tb;   cc = t0;       end
         4: begin ca = t0 + ta;  cb = per - t0;  cc = t0;       end
         default: begin ca = t0; cb = per - t0;  cc = t0 + tb;  end
      endcase
      if (ca > per) ca = per;
      if (cb > per) cb = per;
      if (cc > per) cc = per;
      res.compare_a = ca[15:0];
      res.compare_b = cb[15:0];
      res.compare_c = cc[15:0];
      res.sector = sec[2:0];
      res.sector_angle = sa[13:0];
      expected_compares.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   task automatic push_step(input logic [31:0] step, input logic [13:0] amp);
      pwm_update_type upd;
      upd.step = step;
      upd.amplitude = amp;
      plan_phase = plan_phase + step;
      pwm_updates.push_back(upd);
      pushed_count++;
   endtask

   // steer the accumulator so that its top half lands on a chosen angle
   task automatic push_angle(input logic [15:0] angle, input logic [13:0] amp);
      logic [31:0] target;
      target = {angle, 16'($urandom)};
      push_step(target - plan_phase, amp);
   endtask

   task automatic push_random_update();
      int unsigned kind, amp_kind;
      logic [13:0] amp;
      logic [31:0] sweep;
      kind = $urandom_range(9);
      amp_kind = $urandom_range(7);
      case (amp_kind)
         0: amp = 14'd0;
         1: amp = 14'd16383;
         2: amp = 14'(8192 + $urandom_range(64) - 32);
         default: amp = 14'($urandom_range(16383));
      endcase
      if (kind < 4) begin
         sweep = 32'($urandom_range(1 << 22));
         push_step($urandom_range(1) ? sweep : -sweep, amp);
      end else if (kind < 6) begin
         push_step($urandom, amp);
      end else if (kind < 8) begin
         push_angle(16'($urandom_range(5) * SPAN + $urandom_range(4) - 2), amp);
      end else begin
         push_angle(16'(65528 + $urandom_range(7)), amp);
      end
   endtask

   task automatic wait_drained();
      while (checked_count != pushed_count) @(negedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= PERIOD_ADDR;
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      period_model = value;
      // read back through a second setup and access
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("pwm_period readback", {16'd0, value}, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // driver: take the next update when the channel is free
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_compares(req_angle_step, req_amplitude);
            updates_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pwm_updates.size() != 0 &&
                ((updates_sent >= QUIET_FROM && updates_sent < QUIET_TO) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               next_update = pwm_updates.pop_front();
               req_valid <= 1'b1;
               req_angle_step <= next_update.step;
               req_amplitude <= next_update.amplitude;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each transaction, stall at random, hold off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_compares.size() == 0) begin
               $error("unexpected transaction: sector %0d angle %0d", rsp_sector,
                      rsp_sector_angle);
               mismatches++;
            end else begin
               want = expected_compares.pop_front();
               check_field("compare_a", 32'(want.compare_a), 32'(rsp_compare_a));
               check_field("compare_b", 32'(want.compare_b), 32'(rsp_compare_b));
               check_field("compare_c", 32'(want.compare_c), 32'(rsp_compare_c));
               check_field("sector", 32'(want.sector), 32'(rsp_sector));
               check_field("sector_angle", 32'(want.sector_angle), 32'(rsp_sector_angle));
               checked_count++;
            end
         end
         if (checked_count == HOLD_AT && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (checked_count >= QUIET_FROM && checked_count < QUIET_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [15:0] periods[9];
      periods = '{16'd65535, 16'd1, 16'd0, 16'd2, 16'd3125, 16'd40000, 16'd1, 16'd0, 16'd0};
      periods[6] = 16'($urandom_range(65535, 1));
      periods[7] = 16'($urandom_range(4000, 3));
      periods[8] = 16'($urandom_range(65535, 1));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset period
      push_step(32'd0, 14'd0);
      push_angle(16'd0, 14'd16383);
      push_angle(16'(SPAN - 1), 14'd16383);
      push_angle(16'(SPAN), 14'd8192);
      push_angle(16'(SPAN / 2), 14'd16383);
      push_angle(16'(SPAN / 2), 14'd4096);
      push_angle(16'(2 * SPAN + 3000), 14'd8192);
      push_angle(16'(3 * SPAN + 7000), 14'd9000);
      push_angle(16'(4 * SPAN + 1234), 14'd16383);
      push_angle(16'(5 * SPAN + 9000), 14'd8192);
      push_angle(16'(6 * SPAN - 1), 14'd12000);
      push_angle(16'(6 * SPAN), 14'd8192);
      push_angle(16'hFFFF, 14'd16383);
      push_step(32'h7FFF_FFFF, 14'd1);
      push_step(32'h8000_0000, 14'd16383);
      push_step(32'hFFFF_FFFF, 14'd8191);
      push_step(32'h0000_0001, 14'd10922);
      push_step(32'h5555_5555, 14'h2AAA);
      push_step(32'hAAAA_AAAA, 14'h1555);
      wait_drained();

      foreach (periods[i]) begin
         write_period(periods[i]);
         repeat (PHASE_ITEMS) push_random_update();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_compares.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
